[rtl/tsipc_pkg.sv]
// Shared types and constants for the thread scheduler and IPC rendezvous unit.
package tsipc_pkg;

	localparam int THREAD_COUNT = 8;
	localparam int TID_W = $clog2(THREAD_COUNT);
	localparam int PARTNER_W = TID_W + 1;
	localparam int SIZE_W = 32;
	localparam int IN_W = 48;
	localparam int OUT_W = 80;

	// Slot states.
	typedef enum logic [1:0] {
		ST_FREE    = 2'd0,
		ST_READY   = 2'd1,
		ST_RUNNING = 2'd2,
		ST_BLOCKED = 2'd3
	} slot_st_t;

	// Command codes.
	localparam logic [2:0] CMD_CREATE = 3'd0;
	localparam logic [2:0] CMD_EXIT   = 3'd1;
	localparam logic [2:0] CMD_YIELD  = 3'd2;
	localparam logic [2:0] CMD_SEND   = 3'd3;
	localparam logic [2:0] CMD_RECV   = 3'd4;

	// Result status codes.
	localparam logic [1:0] STAT_DONE    = 2'd0;
	localparam logic [1:0] STAT_ERROR   = 2'd1;
	localparam logic [1:0] STAT_BLOCKED = 2'd2;

	// Partner code that accepts any sender.
	localparam logic [PARTNER_W-1:0] PARTNER_ANY = PARTNER_W'(THREAD_COUNT);

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic exec;
		logic sched;
	} tsipc_ctl_t;

endpackage

[rtl/thread_scheduler_ipc_rendezvous_unit.sv]
// A request accepted in the wait state passes through the execute, schedule and output
// states in that order; the result is held valid in the output state until it is taken.
// Only one request is in flight: no new request is accepted until the result is taken.
// The round-robin pick is a combinational rotating priority search over the slot table.
// Reset (arst_n low): slot 0 running, all other slots free, partners and sizes zero.
// No clearing pass is needed after reset.
module thread_scheduler_ipc_rendezvous_unit import tsipc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	// command[2:0], peer_tid[10:3], from_any[11], msg_size[43:12], zero fill
	input  logic [IN_W-1:0]  s_axis_tdata,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// status[1:0], ret_value[33:2], running_tid[36:34], idle[37],
	// woken_valid[38], woken_tid[41:39], woken_ret[73:42], zero fill
	output logic [OUT_W-1:0] m_axis_tdata
);

	tsipc_ctl_t ctl;

	tsipc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.ctl       (ctl)
	);

	tsipc_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.in_data  (s_axis_tdata),
		.out_data (m_axis_tdata)
	);

endmodule

[rtl/tsipc_ctrl.sv]
// Controller state machine that sequences one request through the datapath.
module tsipc_ctrl import tsipc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	output tsipc_ctl_t ctl
);

	typedef enum logic [1:0] {S_WAIT, S_EXEC, S_SCHED, S_OUT} state_t;

	state_t state_q;

	// Handshakes and datapath commands.
	assign in_ready  = (state_q == S_WAIT);
	assign out_valid = (state_q == S_OUT);
	assign ctl.load  = in_ready && in_valid;
	assign ctl.exec  = (state_q == S_EXEC);
	assign ctl.sched = (state_q == S_SCHED);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_WAIT;
		end else begin
			unique case (state_q)
				S_WAIT:  if (in_valid) state_q <= S_EXEC;
				S_EXEC:  state_q <= S_SCHED;
				S_SCHED: state_q <= S_OUT;
				S_OUT:   if (out_ready) state_q <= S_WAIT;
				default: state_q <= S_WAIT;
			endcase
		end
	end

endmodule

[rtl/tsipc_dp.sv]
// Datapath: thread table, command execution and round-robin scheduler.
module tsipc_dp import tsipc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  tsipc_ctl_t       ctl,
	input  logic [IN_W-1:0]  in_data,
	output logic [OUT_W-1:0] out_data
);

	slot_st_t             st_q   [THREAD_COUNT];
	logic [PARTNER_W-1:0] part_q [THREAD_COUNT];
	logic [SIZE_W-1:0]    pend_q [THREAD_COUNT];
	logic [TID_W-1:0]     cur_q;

	logic [2:0]        cmd_q;
	logic [7:0]        peer_q;
	logic              any_q;
	logic [SIZE_W-1:0] size_q;

	logic [1:0]        status_q;
	logic [SIZE_W-1:0] ret_q;
	logic [TID_W-1:0]  run_q;
	logic              idle_q;
	logic              wv_q;
	logic [TID_W-1:0]  wtid_q;
	logic [SIZE_W-1:0] wret_q;

	logic [TID_W-1:0] peer3;
	logic             running, peer_bad;
	logic             free_hit, any_hit;
	logic [TID_W-1:0] free_idx, any_idx;
	logic             send_match, recv_hit;
	logic [TID_W-1:0] recv_idx;
	logic [SIZE_W-1:0] pend_sel, len;
	logic [TID_W-1:0] sel_idx;
	logic             rr_hit, do_sched;
	logic [TID_W-1:0] rr_idx, rr_probe;
	logic [THREAD_COUNT-1:0] run_mask;

	assign peer3   = peer_q[TID_W-1:0];
	assign running = (st_q[cur_q] == ST_RUNNING);
	assign peer_bad = (peer_q >= 8'(THREAD_COUNT)) || (peer3 == cur_q) ||
		(st_q[peer3] == ST_FREE);

	// Lowest free slot and lowest slot blocked with the caller as partner, from slot 1 up.
	always_comb begin
		free_hit = 1'b0;
		free_idx = '0;
		any_hit  = 1'b0;
		any_idx  = '0;
		for (int i = THREAD_COUNT - 1; i >= 1; i--) begin
			if (st_q[i] == ST_FREE) begin
				free_hit = 1'b1;
				free_idx = TID_W'(i);
			end
			if (st_q[i] == ST_BLOCKED && part_q[i] == {1'b0, cur_q}) begin
				any_hit = 1'b1;
				any_idx = TID_W'(i);
			end
		end
	end

	// Rendezvous matching and the copy length.
	assign send_match = (st_q[peer3] == ST_BLOCKED) &&
		(part_q[peer3] == {1'b0, cur_q} || part_q[peer3] == PARTNER_ANY);
	assign recv_hit = any_q ? any_hit :
		(st_q[peer3] == ST_BLOCKED && part_q[peer3] == {1'b0, cur_q});
	assign recv_idx = any_q ? any_idx : peer3;
	assign sel_idx  = (cmd_q == CMD_SEND) ? peer3 : recv_idx;
	assign pend_sel = pend_q[sel_idx];
	assign len      = (size_q < pend_sel) ? size_q : pend_sel;

	// Round-robin search for the next ready slot after the current one.
	always_comb begin
		rr_hit   = 1'b0;
		rr_idx   = '0;
		rr_probe = '0;
		for (int i = THREAD_COUNT; i >= 1; i--) begin
			rr_probe = cur_q + TID_W'(i);
			if (st_q[rr_probe] == ST_READY) begin
				rr_hit = 1'b1;
				rr_idx = rr_probe;
			end
		end
	end

	assign do_sched = (cmd_q == CMD_YIELD) || !running;

	// Input capture.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q  <= in_data[2:0];
			peer_q <= in_data[10:3];
			any_q  <= in_data[11];
			size_q <= in_data[43:12];
		end
	end

	// Thread table, command execution and rescheduling.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < THREAD_COUNT; i++) begin
				st_q[i]   <= (i == 0) ? ST_RUNNING : ST_FREE;
				part_q[i] <= '0;
				pend_q[i] <= '0;
			end
			cur_q    <= '0;
			status_q <= STAT_DONE;
			ret_q    <= '0;
			run_q    <= '0;
			idle_q   <= 1'b0;
			wv_q     <= 1'b0;
			wtid_q   <= '0;
			wret_q   <= '0;
		end else if (ctl.exec) begin
			status_q <= STAT_DONE;
			ret_q    <= '0;
			wv_q     <= 1'b0;
			wtid_q   <= '0;
			wret_q   <= '0;
			case (cmd_q)
				CMD_CREATE: begin
					if (free_hit) begin
						st_q[free_idx] <= ST_READY;
						ret_q <= SIZE_W'(free_idx);
					end else begin
						status_q <= STAT_ERROR;
					end
				end
				CMD_EXIT: begin
					if (running) st_q[cur_q] <= ST_FREE;
					else status_q <= STAT_ERROR;
				end
				CMD_SEND: begin
					if (!running || peer_bad) begin
						status_q <= STAT_ERROR;
					end else if (send_match) begin
						st_q[peer3] <= ST_READY;
						wv_q   <= 1'b1;
						wtid_q <= peer3;
						wret_q <= len;
					end else begin
						st_q[cur_q]   <= ST_BLOCKED;
						part_q[cur_q] <= PARTNER_W'(peer3);
						pend_q[cur_q] <= size_q;
						status_q      <= STAT_BLOCKED;
					end
				end
				CMD_RECV: begin
					if (!running || (!any_q && peer_bad)) begin
						status_q <= STAT_ERROR;
					end else if (recv_hit) begin
						st_q[recv_idx] <= ST_READY;
						wv_q   <= 1'b1;
						wtid_q <= recv_idx;
						ret_q  <= len;
					end else begin
						st_q[cur_q]   <= ST_BLOCKED;
						part_q[cur_q] <= any_q ? PARTNER_ANY : PARTNER_W'(peer3);
						pend_q[cur_q] <= size_q;
						status_q      <= STAT_BLOCKED;
					end
				end
				default: ;
			endcase
		end else if (ctl.sched) begin
			if (do_sched && rr_hit) begin
				if (running) st_q[cur_q] <= ST_READY;
				st_q[rr_idx] <= ST_RUNNING;
				cur_q  <= rr_idx;
				run_q  <= rr_idx;
				idle_q <= 1'b0;
			end else begin
				run_q  <= cur_q;
				idle_q <= !running;
			end
		end
	end

	// Result packing, lowest field first.
	assign out_data = {6'd0, wret_q, wtid_q, wv_q, idle_q, run_q, ret_q, status_q};

	always_comb begin
		for (int i = 0; i < THREAD_COUNT; i++) run_mask[i] = (st_q[i] == ST_RUNNING);
	end

`ifndef ASSERT_OFF
	// Never more than one running thread.
	a_one_running: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(run_mask)) else $error("more than one running slot");
	// A running thread is always the current one.
	a_run_is_cur: assert property (@(posedge clk) disable iff (!arst_n)
		(run_mask != '0) |-> run_mask[cur_q]) else $error("running slot not current");
	// A reported wake never names the caller.
	a_wake_other: assert property (@(posedge clk) disable iff (!arst_n)
		$past(ctl.exec) && wv_q |-> (wtid_q != $past(cur_q)))
		else $error("caller woke itself");
`endif

endmodule
